// File: rtl/c8core_pkg.sv
`default_nettype none

package c8core_pkg;

	localparam int MEM_BYTES   = 4096;
	localparam int STACK_DEPTH = 16;
	localparam int MEM_AW      = $clog2(MEM_BYTES);
	localparam int SIDX_W      = $clog2(STACK_DEPTH);

	localparam logic [11:0] PROG_BASE  = 12'h200;
	localparam int          FONT_BASE  = 'h050;
	localparam int          FONT_BYTES = 80;

	localparam logic [15:0] RET_OPCODE = 16'h00EE;

	localparam logic [3:0] OP_SYS  = 4'h0;
	localparam logic [3:0] OP_JP   = 4'h1;
	localparam logic [3:0] OP_CALL = 4'h2;
	localparam logic [3:0] OP_SEI  = 4'h3;
	localparam logic [3:0] OP_SNEI = 4'h4;
	localparam logic [3:0] OP_SER  = 4'h5;
	localparam logic [3:0] OP_LDI  = 4'h6;
	localparam logic [3:0] OP_ADDI = 4'h7;
	localparam logic [3:0] OP_ALU  = 4'h8;
	localparam logic [3:0] OP_SNER = 4'h9;
	localparam logic [3:0] OP_LDIX = 4'hA;

	localparam logic [3:0] ALU_MOV = 4'h0;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_UNDER  = 2'd1;
	localparam logic [1:0] STAT_OVER   = 2'd2;
	localparam logic [1:0] STAT_NOEXEC = 2'd3;

	localparam logic [7:0] FONT [FONT_BYTES] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOAD,
		S_DECODE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic              en;
		logic [MEM_AW-1:0] addr;
		logic [7:0]        data;
	} mem_wr_t;

	typedef struct packed {
		logic       en;
		logic [3:0] num;
		logic [7:0] val;
	} vreg_wr_t;

	typedef struct packed {
		logic              en;
		logic [SIDX_W-1:0] idx;
		logic [11:0]       pc;
	} stk_wr_t;

	// 12-bit address folded into the memory size, at most three folds
	function automatic logic [MEM_AW-1:0] mem_wrap(input logic [11:0] a);
		logic [12:0] v;
		v = {1'b0, a};
		for (int k = 0; k < 3; k++) begin
			if (v >= 13'(MEM_BYTES)) begin
				v = v - 13'(MEM_BYTES);
			end
		end
		return v[MEM_AW-1:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/chip8_cpu_core_subset.sv
// channel  handshake             payload
// in       in_valid / in_ready   cmd, load_addr, load_byte
// out      out_valid / out_ready fetched_opcode, pc_after, index_after, status,
//                                reg_written, reg_number, reg_value, skipped
//
// a step reads the opcode bytes from the byte memory, then reads the register
// file and stack, then executes with write-back; a load writes its byte in the load state.
// after reset a clearing pass over all MEM_BYTES (4096) addresses writes the font and
// zeros; in_ready stays low during it.
// one item is worked at a time; the result register lets the next item enter
// while a result waits, and execute or load holds while that register is full and out_ready is low.
`default_nettype none

module chip8_cpu_core_subset (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        cmd,
	input  wire logic [11:0] load_addr,
	input  wire logic [7:0]  load_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [15:0] fetched_opcode,
	output logic      [11:0] pc_after,
	output logic      [11:0] index_after,
	output logic      [1:0]  status,
	output logic             reg_written,
	output logic      [3:0]  reg_number,
	output logic      [7:0]  reg_value,
	output logic             skipped
);

	localparam int MAW = c8core_pkg::MEM_AW;
	localparam int SIW = c8core_pkg::SIDX_W;

	c8core_pkg::state_t state_q, state_nxt;

	logic [MAW-1:0] clr_cnt_q;
	logic [11:0]    pc_q;
	logic [11:0]    i_q;
	logic [4:0]     sp_q;
	logic [15:0]    op_q;
	logic [11:0]    ld_addr_q;
	logic [7:0]     ld_byte_q;
	logic           out_valid_q;

	logic           slot_free;
	logic           clr_last;
	logic           mem_rd_en;
	logic           reg_rd_en;
	logic           ex_fire;
	logic           ld_fire;
	logic [7:0]     mem_rd0;
	logic [7:0]     mem_rd1;
	logic [7:0]     vx;
	logic [7:0]     vy;
	logic [11:0]    stk_pc;
	logic [15:0]    opcode;
	logic [7:0]     clr_data;

	c8core_pkg::mem_wr_t  mem_wr;
	c8core_pkg::vreg_wr_t vreg_wr;
	c8core_pkg::stk_wr_t  stk_wr;

	logic [11:0] ex_pc;
	logic [11:0] ex_i;
	logic [4:0]  ex_sp;
	logic [1:0]  ex_status;
	logic        ex_wr;
	logic [3:0]  ex_num;
	logic [7:0]  ex_val;
	logic        ex_skip;
	logic        ex_push;

	assign slot_free = !out_valid_q || out_ready;
	assign clr_last  = (clr_cnt_q == MAW'(c8core_pkg::MEM_BYTES - 1));
	assign opcode    = {mem_rd0, mem_rd1};

	c8core_mem u_mem (
		.clk      (clk),
		.wr       (mem_wr),
		.rd_en    (mem_rd_en),
		.rd_addr0 (c8core_pkg::mem_wrap(pc_q)),
		.rd_addr1 (c8core_pkg::mem_wrap(pc_q + 12'd1)),
		.rd_data0 (mem_rd0),
		.rd_data1 (mem_rd1)
	);

	c8core_vregs u_vregs (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (vreg_wr),
		.rd_en  (reg_rd_en),
		.rd_x   (opcode[11:8]),
		.rd_y   (opcode[7:4]),
		.vx     (vx),
		.vy     (vy)
	);

	c8core_stack u_stack (
		.clk    (clk),
		.wr     (stk_wr),
		.rd_en  (reg_rd_en),
		.rd_idx (SIW'(sp_q - 5'd1)),
		.rd_pc  (stk_pc)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			c8core_pkg::S_CLEAR: begin
				if (clr_last) begin
					state_nxt = c8core_pkg::S_IDLE;
				end
			end
			c8core_pkg::S_IDLE: begin
				if (in_valid) begin
					state_nxt = cmd ? c8core_pkg::S_DECODE : c8core_pkg::S_LOAD;
				end
			end
			c8core_pkg::S_LOAD: begin
				if (slot_free) begin
					state_nxt = c8core_pkg::S_IDLE;
				end
			end
			c8core_pkg::S_DECODE: begin
				state_nxt = c8core_pkg::S_EXEC;
			end
			c8core_pkg::S_EXEC: begin
				if (slot_free) begin
					state_nxt = c8core_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = c8core_pkg::S_CLEAR;
			end
		endcase
	end

	// state outputs
	always_comb begin
		in_ready  = 1'b0;
		mem_rd_en = 1'b0;
		reg_rd_en = 1'b0;
		ex_fire   = 1'b0;
		ld_fire   = 1'b0;
		case (state_q)
			c8core_pkg::S_IDLE: begin
				in_ready  = 1'b1;
				mem_rd_en = 1'b1;
			end
			c8core_pkg::S_LOAD: begin
				ld_fire = slot_free;
			end
			c8core_pkg::S_DECODE: begin
				reg_rd_en = 1'b1;
			end
			c8core_pkg::S_EXEC: begin
				ex_fire = slot_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// execute
	always_comb begin
		logic [11:0] pc2;
		pc2       = pc_q + 12'd2;
		ex_pc     = pc2;
		ex_i      = i_q;
		ex_sp     = sp_q;
		ex_status = c8core_pkg::STAT_OK;
		ex_wr     = 1'b0;
		ex_num    = 4'd0;
		ex_val    = 8'd0;
		ex_skip   = 1'b0;
		ex_push   = 1'b0;
		case (op_q[15:12])
			c8core_pkg::OP_SYS: begin
				if (op_q == c8core_pkg::RET_OPCODE) begin
					if (sp_q == 5'd0) begin
						ex_status = c8core_pkg::STAT_UNDER;
					end else begin
						ex_sp = sp_q - 5'd1;
						ex_pc = stk_pc;
					end
				end else begin
					ex_status = c8core_pkg::STAT_NOEXEC;
				end
			end
			c8core_pkg::OP_JP: begin
				ex_pc = op_q[11:0];
			end
			c8core_pkg::OP_CALL: begin
				if (sp_q >= 5'(c8core_pkg::STACK_DEPTH)) begin
					ex_status = c8core_pkg::STAT_OVER;
				end else begin
					ex_push = 1'b1;
					ex_sp   = sp_q + 5'd1;
					ex_pc   = op_q[11:0];
				end
			end
			c8core_pkg::OP_SEI: begin
				ex_skip = (vx == op_q[7:0]);
			end
			c8core_pkg::OP_SNEI: begin
				ex_skip = (vx != op_q[7:0]);
			end
			c8core_pkg::OP_SER: begin
				ex_skip = (vx == vy);
			end
			c8core_pkg::OP_SNER: begin
				ex_skip = (vx != vy);
			end
			c8core_pkg::OP_LDI: begin
				ex_wr  = 1'b1;
				ex_num = op_q[11:8];
				ex_val = op_q[7:0];
			end
			c8core_pkg::OP_ADDI: begin
				ex_wr  = 1'b1;
				ex_num = op_q[11:8];
				ex_val = vx + op_q[7:0];
			end
			c8core_pkg::OP_ALU: begin
				if (op_q[3:0] == c8core_pkg::ALU_MOV) begin
					ex_wr  = 1'b1;
					ex_num = op_q[11:8];
					ex_val = vy;
				end else begin
					ex_status = c8core_pkg::STAT_NOEXEC;
				end
			end
			c8core_pkg::OP_LDIX: begin
				ex_i = op_q[11:0];
			end
			default: begin
				ex_status = c8core_pkg::STAT_NOEXEC;
			end
		endcase
		if (ex_skip) begin
			ex_pc = pc_q + 12'd4;
		end
	end

	// font window during the clearing pass
	always_comb begin
		clr_data = 8'd0;
		if (clr_cnt_q >= MAW'(c8core_pkg::FONT_BASE)
				&& clr_cnt_q < MAW'(c8core_pkg::FONT_BASE + c8core_pkg::FONT_BYTES)) begin
			clr_data = c8core_pkg::FONT[7'(clr_cnt_q - MAW'(c8core_pkg::FONT_BASE))];
		end
	end

	always_comb begin
		mem_wr.en   = 1'b0;
		mem_wr.addr = c8core_pkg::mem_wrap(ld_addr_q);
		mem_wr.data = ld_byte_q;
		if (state_q == c8core_pkg::S_CLEAR) begin
			mem_wr.en   = 1'b1;
			mem_wr.addr = clr_cnt_q;
			mem_wr.data = clr_data;
		end else if (ld_fire) begin
			mem_wr.en = 1'b1;
		end
	end

	assign vreg_wr.en  = ex_fire && ex_wr;
	assign vreg_wr.num = ex_num;
	assign vreg_wr.val = ex_val;

	assign stk_wr.en  = ex_fire && ex_push;
	assign stk_wr.idx = SIW'(sp_q);
	assign stk_wr.pc  = pc_q + 12'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= c8core_pkg::S_CLEAR;
			clr_cnt_q   <= '0;
			pc_q        <= c8core_pkg::PROG_BASE;
			i_q         <= 12'd0;
			sp_q        <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == c8core_pkg::S_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + MAW'(1);
			end
			if (ex_fire) begin
				pc_q <= ex_pc;
				i_q  <= ex_i;
				sp_q <= ex_sp;
			end
			if (ex_fire || ld_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ld_addr_q <= load_addr;
			ld_byte_q <= load_byte;
		end
		if (state_q == c8core_pkg::S_DECODE) begin
			op_q <= opcode;
		end
		if (ex_fire) begin
			fetched_opcode <= op_q;
			pc_after       <= ex_pc;
			index_after    <= ex_i;
			status         <= ex_status;
			reg_written    <= ex_wr;
			reg_number     <= ex_num;
			reg_value      <= ex_val;
			skipped        <= ex_skip;
		end else if (ld_fire) begin
			fetched_opcode <= 16'd0;
			pc_after       <= pc_q;
			index_after    <= i_q;
			status         <= c8core_pkg::STAT_OK;
			reg_written    <= 1'b0;
			reg_number     <= 4'd0;
			reg_value      <= 8'd0;
			skipped        <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= 5'(c8core_pkg::STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	a_step_path: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && cmd) |=> state_q == c8core_pkg::S_DECODE)
		else $error("step transaction did not enter decode");

	a_pc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ex_fire |=> $stable(pc_q))
		else $error("program counter moved outside execute");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ex_fire || ld_fire))
		else $error("result appeared without a finished transaction");

	a_wb_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(vreg_wr.en || stk_wr.en) |-> (state_q == c8core_pkg::S_EXEC && slot_free))
		else $error("write-back outside a completing execute");

endmodule

`default_nettype wire

// File: rtl/c8core_mem.sv
`default_nettype none

module c8core_mem (
	input  wire logic                          clk,
	input  wire c8core_pkg::mem_wr_t           wr,
	input  wire logic                          rd_en,
	input  wire logic [c8core_pkg::MEM_AW-1:0] rd_addr0,
	input  wire logic [c8core_pkg::MEM_AW-1:0] rd_addr1,
	output logic      [7:0]                    rd_data0,
	output logic      [7:0]                    rd_data1
);

	logic [7:0] mem [c8core_pkg::MEM_BYTES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data0 <= mem[rd_addr0];
			rd_data1 <= mem[rd_addr1];
		end
	end

endmodule

`default_nettype wire

// File: rtl/c8core_vregs.sv
`default_nettype none

module c8core_vregs (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire c8core_pkg::vreg_wr_t wr,
	input  wire logic                 rd_en,
	input  wire logic [3:0]           rd_x,
	input  wire logic [3:0]           rd_y,
	output logic      [7:0]           vx,
	output logic      [7:0]           vy
);

	logic [7:0]  mem [16];
	logic [15:0] vld_q;
	logic [7:0]  vx_q;
	logic [7:0]  vy_q;
	logic        vx_vld_q;
	logic        vy_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.num] <= wr.val;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			vx_q <= mem[rd_x];
			vy_q <= mem[rd_y];
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vx_vld_q <= 1'b0;
			vy_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.num] <= 1'b1;
			end
			if (rd_en) begin
				vx_vld_q <= vld_q[rd_x];
				vy_vld_q <= vld_q[rd_y];
			end
		end
	end

	assign vx = vx_vld_q ? vx_q : 8'd0;
	assign vy = vy_vld_q ? vy_q : 8'd0;

endmodule

`default_nettype wire

// File: rtl/c8core_stack.sv
`default_nettype none

module c8core_stack (
	input  wire logic                          clk,
	input  wire c8core_pkg::stk_wr_t           wr,
	input  wire logic                          rd_en,
	input  wire logic [c8core_pkg::SIDX_W-1:0] rd_idx,
	output logic      [11:0]                   rd_pc
);

	logic [11:0] mem [c8core_pkg::STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.pc;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_pc <= mem[rd_idx];
		end
	end

endmodule

`default_nettype wire
